// File: rtl/c2c_pkg.sv
package c2c_pkg;

  localparam int ROW_W = 10;
  localparam int COL_W = 16;
  localparam int VAL_W = 64;
  localparam int PTR_W = 13;
  localparam int CFG_W = 11;

  localparam logic [1:0] KIND_PTR   = 2'd0;
  localparam logic [1:0] KIND_ENTRY = 2'd1;
  localparam logic [1:0] KIND_NONE  = 2'd2;

  localparam logic [1:0] PH_LOADING = 2'd0;
  localparam logic [1:0] PH_READING = 2'd1;
  localparam logic [1:0] PH_DONE    = 2'd2;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_READ = 1'b1;

  typedef struct packed {
    logic             is_read;
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] column;
    logic [VAL_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]       kind;
    logic [PTR_W-1:0] pointer;
    logic [COL_W-1:0] column;
    logic [VAL_W-1:0] value;
    logic             error;
    logic             last;
  } res_t;

endpackage

// File: rtl/c2c_queue.sv
module c2c_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  c2c_pkg::cmd_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output c2c_pkg::cmd_t out_data
);

  c2c_pkg::cmd_t slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;
  logic       push;
  logic       pop;

  assign in_ready  = (fill != 2'd2);
  assign out_valid = (fill != 2'd0);
  assign out_data  = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        fill <= fill + 2'd1;
      end else if (pop && !push) begin
        fill <= fill - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_data;
    end
  end

endmodule

// File: rtl/c2c_front.sv
module c2c_front #(
  parameter int COLUMN_BITS = 16
) (
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [95:0]   s_axis_tdata,
  input  logic          s_axis_tuser,
  input  logic          clearing,
  output logic          q_valid,
  input  logic          q_ready,
  output c2c_pkg::cmd_t q_data
);

  logic [31:0] col_w;
  logic [31:0] col_mask;

  // columns keep only the low COLUMN_BITS bits
  assign col_mask = (COLUMN_BITS >= 32) ? 32'hFFFF_FFFF : ((32'd1 << COLUMN_BITS) - 32'd1);
  assign col_w    = 32'(s_axis_tdata[25:10]) & col_mask;

  always_comb begin
    q_data.is_read = (s_axis_tuser == c2c_pkg::MODE_READ);
    q_data.row     = s_axis_tdata[9:0];
    q_data.column  = col_w[15:0];
    q_data.value   = s_axis_tdata[89:26];
  end

  assign q_valid       = s_axis_tvalid && !clearing;
  assign s_axis_tready = q_ready && !clearing;

endmodule

// File: rtl/c2c_back.sv
module c2c_back #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_ENTRIES = 4096,
  parameter int COLUMN_BITS = 16
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  c2c_pkg::cmd_t cmd,
  input  logic          cfg_valid,
  input  logic [10:0]   cfg_data,
  output logic          clearing,
  output logic          res_valid,
  input  logic          res_ready,
  output c2c_pkg::res_t res
);

  localparam int RAW   = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int EAW   = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int RIW   = $clog2(MAX_ROWS + 1);
  localparam int RPW   = CNT_W + 12;

  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_LD_WR  = 4'd2;
  localparam logic [3:0] ST_PFX    = 4'd3;
  localparam logic [3:0] ST_SCT_A  = 4'd4;
  localparam logic [3:0] ST_SCT_B  = 4'd5;
  localparam logic [3:0] ST_SCT_C  = 4'd6;
  localparam logic [3:0] ST_EM_REQ = 4'd7;
  localparam logic [3:0] ST_EM_OUT = 4'd8;

  // memories
  logic [CNT_W-1:0]       rc_mem [MAX_ROWS];
  logic [CNT_W-1:0]       fp_mem [MAX_ROWS];
  logic [c2c_pkg::ROW_W-1:0] er_mem [MAX_ENTRIES];
  logic [COLUMN_BITS-1:0] ec_mem [MAX_ENTRIES];
  logic [63:0]            ev_mem [MAX_ENTRIES];
  logic [COLUMN_BITS-1:0] sc_mem [MAX_ENTRIES];
  logic [63:0]            sv_mem [MAX_ENTRIES];

  logic                   rc_we, rc_re, fp_we, fp_re, e_we, e_re, s_we, s_re;
  logic [RAW-1:0]         rc_wa, rc_ra, fp_wa, fp_ra;
  logic [CNT_W-1:0]       rc_wd, fp_wd, rc_rd, fp_rd;
  logic [EAW-1:0]         e_wa, e_ra, s_wa, s_ra;
  logic [c2c_pkg::ROW_W-1:0] er_rd;
  logic [COLUMN_BITS-1:0] e_wc, ec_rd, sc_rd;
  logic [63:0]            ev_rd, sv_rd;

  logic [3:0]       state, state_next;
  logic [1:0]       phase;
  logic [10:0]      rows_cfg;
  logic [10:0]      rows_eff;
  logic [CNT_W-1:0] loaded;
  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] sum;
  logic [CNT_W-1:0] sidx;
  logic [RPW-1:0]   rp;
  logic             dropped;
  logic [RIW-1:0]   idx;
  logic             rd_vld;
  logic [RAW-1:0]   rd_addr;
  logic [RAW-1:0]   ld_addr;
  logic             ov;
  logic             out_free;
  logic [31:0]      row_w, col_w, rp_w, pm1_w, k_w, er_w;
  logic             ld_drop;
  logic             is_ptr;
  logic             is_last;
  c2c_pkg::res_t    res_new;

  assign rows_eff = (32'(rows_cfg) > 32'(MAX_ROWS)) ? 11'(MAX_ROWS) : rows_cfg;
  assign row_w    = 32'(cmd.row);
  assign col_w    = 32'(cmd.column);
  assign rp_w     = 32'(rp);
  assign pm1_w    = rp_w - 32'd1;
  assign k_w      = rp_w - 32'(rows_eff) - 32'd1;
  assign er_w     = 32'(er_rd);
  assign ld_drop  = (row_w >= 32'(rows_eff)) || (loaded >= CNT_W'(MAX_ENTRIES));
  assign is_ptr   = (rp_w <= 32'(rows_eff));
  assign out_free = !ov || res_ready;
  assign clearing = (state == ST_CLR);
  assign cmd_ready = (state == ST_IDLE);
  assign res_valid = ov;
  assign e_wc      = col_w[COLUMN_BITS-1:0];

  always_comb begin
    if (phase == c2c_pkg::PH_DONE) begin
      is_last = 1'b0;
    end else if (is_ptr) begin
      is_last = (rp_w == 32'(rows_eff)) && (total == '0);
    end else begin
      is_last = (k_w + 32'd1 >= 32'(total));
    end
  end

  always_comb begin
    res_new = '0;
    res_new.error = dropped;
    res_new.last  = is_last;
    if (phase == c2c_pkg::PH_DONE) begin
      res_new.kind = c2c_pkg::KIND_NONE;
    end else if (is_ptr) begin
      res_new.kind    = c2c_pkg::KIND_PTR;
      res_new.pointer = (rp == '0) ? '0 : 13'(32'(fp_rd));
    end else begin
      res_new.kind   = c2c_pkg::KIND_ENTRY;
      res_new.column = 16'(32'(sc_rd));
      res_new.value  = sv_rd;
    end
  end

  // memory port control
  always_comb begin
    rc_we = 1'b0; rc_wa = '0; rc_wd = '0; rc_re = 1'b0; rc_ra = '0;
    fp_we = 1'b0; fp_wa = '0; fp_wd = '0; fp_re = 1'b0; fp_ra = '0;
    e_we  = 1'b0; e_wa  = loaded[EAW-1:0]; e_re = 1'b0; e_ra = sidx[EAW-1:0];
    s_we  = 1'b0; s_wa  = fp_rd[EAW-1:0];  s_re = 1'b0; s_ra = k_w[EAW-1:0];
    case (state)
      ST_CLR: begin
        rc_we = 1'b1;
        rc_wa = idx[RAW-1:0];
      end
      ST_IDLE: begin
        if (cmd_valid && !cmd.is_read && phase != c2c_pkg::PH_READING && !ld_drop) begin
          e_we  = 1'b1;
          rc_re = 1'b1;
          rc_ra = row_w[RAW-1:0];
        end
      end
      ST_LD_WR: begin
        rc_we = 1'b1;
        rc_wa = ld_addr;
        rc_wd = rc_rd + CNT_W'(1);
      end
      ST_PFX: begin
        if (32'(idx) < 32'(MAX_ROWS)) begin
          rc_re = 1'b1;
          rc_ra = idx[RAW-1:0];
        end
        // counts are zeroed as they are summed, for every row
        if (rd_vld) begin
          rc_we = 1'b1;
          rc_wa = rd_addr;
          if (32'(rd_addr) < 32'(rows_eff)) begin
            fp_we = 1'b1;
            fp_wa = rd_addr;
            fp_wd = sum;
          end
        end
      end
      ST_SCT_A: begin
        e_re = (sidx != loaded);
      end
      ST_SCT_B: begin
        if (er_w < 32'(rows_eff)) begin
          fp_re = 1'b1;
          fp_ra = er_w[RAW-1:0];
        end
      end
      ST_SCT_C: begin
        fp_we = 1'b1;
        fp_wa = er_w[RAW-1:0];
        fp_wd = fp_rd + CNT_W'(1);
        s_we  = 1'b1;
      end
      ST_EM_REQ: begin
        if (phase == c2c_pkg::PH_READING) begin
          if (is_ptr) begin
            fp_re = (rp != '0);
            fp_ra = pm1_w[RAW-1:0];
          end else begin
            s_re = 1'b1;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rc_we) begin
      rc_mem[rc_wa] <= rc_wd;
    end
    if (rc_re) begin
      rc_rd <= rc_mem[rc_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (fp_we) begin
      fp_mem[fp_wa] <= fp_wd;
    end
    if (fp_re) begin
      fp_rd <= fp_mem[fp_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      er_mem[e_wa] <= cmd.row;
      ec_mem[e_wa] <= e_wc;
      ev_mem[e_wa] <= cmd.value;
    end
    if (e_re) begin
      er_rd <= er_mem[e_ra];
      ec_rd <= ec_mem[e_ra];
      ev_rd <= ev_mem[e_ra];
    end
  end

  always_ff @(posedge clk) begin
    if (s_we) begin
      sc_mem[s_wa] <= ec_rd;
      sv_mem[s_wa] <= ev_rd;
    end
    if (s_re) begin
      sc_rd <= sc_mem[s_ra];
      sv_rd <= sv_mem[s_ra];
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLR: begin
        if (32'(idx) == 32'(MAX_ROWS) - 32'd1) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_valid) begin
          if (cmd.is_read) begin
            state_next = (phase == c2c_pkg::PH_LOADING) ? ST_PFX : ST_EM_REQ;
          end else if (phase != c2c_pkg::PH_READING && !ld_drop) begin
            state_next = ST_LD_WR;
          end
        end
      end
      ST_LD_WR:  state_next = ST_IDLE;
      ST_PFX: begin
        if (32'(idx) == 32'(MAX_ROWS) && !rd_vld) begin
          state_next = ST_SCT_A;
        end
      end
      ST_SCT_A:  state_next = (sidx == loaded) ? ST_EM_REQ : ST_SCT_B;
      ST_SCT_B:  state_next = (er_w < 32'(rows_eff)) ? ST_SCT_C : ST_SCT_A;
      ST_SCT_C:  state_next = ST_SCT_A;
      ST_EM_REQ: state_next = ST_EM_OUT;
      ST_EM_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLR;
      phase    <= c2c_pkg::PH_LOADING;
      rows_cfg <= 11'd1024;
      loaded   <= '0;
      total    <= '0;
      sum      <= '0;
      sidx     <= '0;
      rp       <= '0;
      dropped  <= 1'b0;
      idx      <= '0;
      rd_vld   <= 1'b0;
      ov       <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && phase != c2c_pkg::PH_READING) begin
        rows_cfg <= cfg_data;
      end
      if (state == ST_EM_OUT && out_free) begin
        ov <= 1'b1;
      end else if (res_ready) begin
        ov <= 1'b0;
      end
      case (state)
        ST_CLR: begin
          idx <= idx + RIW'(1);
        end
        ST_IDLE: begin
          idx    <= '0;
          sum    <= '0;
          rd_vld <= 1'b0;
          if (cmd_valid && !cmd.is_read && phase != c2c_pkg::PH_READING) begin
            phase <= c2c_pkg::PH_LOADING;
            if (ld_drop) begin
              dropped <= 1'b1;
            end else begin
              loaded <= loaded + CNT_W'(1);
            end
          end
        end
        ST_PFX: begin
          rd_vld  <= (32'(idx) < 32'(MAX_ROWS));
          rd_addr <= idx[RAW-1:0];
          if (32'(idx) < 32'(MAX_ROWS)) begin
            idx <= idx + RIW'(1);
          end
          if (rd_vld && 32'(rd_addr) < 32'(rows_eff)) begin
            sum <= sum + rc_rd;
          end
          total <= sum;
          sidx  <= '0;
        end
        ST_SCT_A: begin
          if (sidx == loaded) begin
            phase <= c2c_pkg::PH_READING;
            rp    <= '0;
          end
        end
        ST_SCT_B: begin
          if (er_w >= 32'(rows_eff)) begin
            dropped <= 1'b1;
            sidx    <= sidx + CNT_W'(1);
          end
        end
        ST_SCT_C: begin
          sidx <= sidx + CNT_W'(1);
        end
        ST_EM_OUT: begin
          if (out_free && phase == c2c_pkg::PH_READING) begin
            if (is_last) begin
              loaded  <= '0;
              total   <= '0;
              dropped <= 1'b0;
              rp      <= '0;
              phase   <= c2c_pkg::PH_DONE;
            end else begin
              rp <= rp + RPW'(1);
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && cmd_valid && !cmd.is_read) begin
      ld_addr <= row_w[RAW-1:0];
    end
    if (state == ST_EM_OUT && out_free) begin
      res <= res_new;
    end
  end

endmodule

// File: rtl/coo_to_csr_converter_top.sv
// Load word: passes through the queue, then the back end reads the row count and writes it back.
// First read of a matrix: the word is taken, a prefix-sum sweep runs over the row counts,
// each stored entry is scattered into place, then the result register is loaded.
// Every further read: word taken, at most one memory read, one output register load.
// Reset: synchronous; afterwards a clearing sweep zeroes all MAX_ROWS row counts, during which
// s_axis_tready stays low. Config writes are taken throughout, but ignored in the reading phase.
module coo_to_csr_converter_top #(
  parameter int MAX_ROWS    = 1024,
  parameter int MAX_ENTRIES = 4096,
  parameter int COLUMN_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [95:0] s_axis_tdata,  // row[9:0], column[25:10], value[89:26], zero pad
  input  logic        s_axis_tuser,  // mode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [95:0] m_axis_tdata,  // pointer[12:0], out_column[28:13], out_value[92:29],
                                     // error[93], zero pad
  output logic [1:0]  m_axis_tuser,  // kind
  output logic        m_axis_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [10:0] cfg_data
);

  c2c_pkg::cmd_t f_cmd, q_cmd;
  c2c_pkg::res_t res;
  logic          f_valid, f_ready, q_valid, q_ready, clearing;

  assign cfg_ready = 1'b1;

  c2c_front #(.COLUMN_BITS(COLUMN_BITS)) u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clearing      (clearing),
    .q_valid       (f_valid),
    .q_ready       (f_ready),
    .q_data        (f_cmd)
  );

  c2c_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_data   (f_cmd),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_data  (q_cmd)
  );

  c2c_back #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_ENTRIES (MAX_ENTRIES),
    .COLUMN_BITS (COLUMN_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .clearing  (clearing),
    .res_valid (m_axis_tvalid),
    .res_ready (m_axis_tready),
    .res       (res)
  );

  assign m_axis_tdata = {2'b00, res.error, res.value, res.column, res.pointer};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule

// File: rtl/c2c_checker.sv
module c2c_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [95:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser,
  input logic        m_axis_tlast
);

  // stalled result word holds
  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("stalled result changed");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == c2c_pkg::KIND_NONE |-> !m_axis_tlast
      && m_axis_tdata[92:0] == '0)
    else $error("empty word carries data or last");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == c2c_pkg::KIND_PTR |-> m_axis_tdata[92:13] == '0)
    else $error("pointer word carries entry data");

  assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == c2c_pkg::KIND_ENTRY |-> m_axis_tdata[12:0] == '0)
    else $error("entry word carries pointer");

endmodule

bind coo_to_csr_converter_top c2c_checker u_c2c_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
